// ===== sv/btd_pkg.sv =====
// ----------------------------------------------------------------------------
// btd_pkg
// shared types and constants of the threshold and dilation block
// ----------------------------------------------------------------------------
package btd_pkg;

    localparam int W_W    = 11;     // image width register
    localparam int H_W    = 12;     // image height register
    localparam int LIM_W  = 18;     // squared magnitude limit
    localparam int FS_W   = 23;     // pixels per frame
    localparam int SQ_W   = 16;     // one squared channel
    localparam int CIDX_W = 2;      // configuration index

    localparam int MIN_SIDE   = 5;
    localparam int MAX_HEIGHT = 4095;

    localparam logic [W_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [H_W-1:0]   RST_HEIGHT = 12'd480;
    localparam logic [LIM_W-1:0] RST_LIMIT  = 18'd16384;   // 128 squared
    localparam logic [FS_W-1:0]  RST_FSIZE  = 23'd307200;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DARK   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [W_W-1:0]  w;
        logic [H_W-1:0]  h;
        logic [FS_W-1:0] fsize;
    } t_geom;

    // one step of the cascade: valid is a real item, have is a pixel present
    typedef struct packed {
        logic valid;
        logic have;
        logic pix;
        logic last;
    } t_tok;

    typedef struct packed {
        logic have;
        logic pix;
    } t_qent;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== sv/btd_in_if.sv =====
// ----------------------------------------------------------------------------
// btd_in_if
// pixel channel: valid, ready and one rgb pixel or flush
// ----------------------------------------------------------------------------
interface btd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, kind, blue, green, red, input ready);
    modport sink   (input valid, kind, blue, green, red, output ready);
endinterface

// ===== sv/btd_out_if.sv =====
// ----------------------------------------------------------------------------
// btd_out_if
// result channel: valid, ready and one binary pixel
// ----------------------------------------------------------------------------
interface btd_out_if;
    logic valid;
    logic ready;
    logic is_white;
    logic frame_last;

    modport source (output valid, is_white, frame_last, input ready);
    modport sink   (input valid, is_white, frame_last, output ready);
endinterface

// ===== sv/btd_front.sv =====
// ----------------------------------------------------------------------------
// btd_front
// accepts pixels, squares the channels and classifies black or white
// ----------------------------------------------------------------------------
module btd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    btd_in_if.sink                        i_in,
    input  logic [btd_pkg::LIM_W-1:0]     i_limit,
    input  btd_pkg::t_qstat               i_qstat,
    output logic                          o_push,
    output btd_pkg::t_qent                o_ent
);

    logic                       r_av;
    logic                       r_have;
    logic [btd_pkg::SQ_W-1:0]   r_sq_b;
    logic [btd_pkg::SQ_W-1:0]   r_sq_g;
    logic [btd_pkg::SQ_W-1:0]   r_sq_r;
    logic [btd_pkg::LIM_W-1:0]  sum;
    logic                       take;

    assign o_push     = r_av && !i_qstat.full;
    assign i_in.ready = !r_av || !i_qstat.full;
    assign take       = i_in.valid && i_in.ready;

    assign sum = btd_pkg::LIM_W'(r_sq_b) + btd_pkg::LIM_W'(r_sq_g)
               + btd_pkg::LIM_W'(r_sq_r);

    // white unless below the limit
    assign o_ent.have = r_have;
    assign o_ent.pix  = (sum >= i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (take) begin
            r_av <= 1'b1;
        end else if (o_push) begin
            r_av <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_have <= !i_in.kind;
            r_sq_b <= btd_pkg::SQ_W'(i_in.blue) * btd_pkg::SQ_W'(i_in.blue);
            r_sq_g <= btd_pkg::SQ_W'(i_in.green) * btd_pkg::SQ_W'(i_in.green);
            r_sq_r <= btd_pkg::SQ_W'(i_in.red) * btd_pkg::SQ_W'(i_in.red);
        end
    end

endmodule

// ===== sv/btd_queue.sv =====
// ----------------------------------------------------------------------------
// btd_queue
// short queue between the classifier and the dilation cascade
// ----------------------------------------------------------------------------
module btd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  btd_pkg::t_qent  i_ent,
    input  logic            i_pop,
    output btd_pkg::t_qent  o_ent,
    output btd_pkg::t_qstat o_stat
);

    btd_pkg::t_qent             r_mem [btd_pkg::Q_DEPTH];
    logic [btd_pkg::Q_PW-1:0]   r_wp;
    logic [btd_pkg::Q_PW-1:0]   r_rp;
    logic [btd_pkg::Q_CW-1:0]   r_cnt;
    logic                       push_ok;
    logic                       pop_ok;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == btd_pkg::Q_CW'(btd_pkg::Q_DEPTH));
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_ent        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (pop_ok)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + btd_pkg::Q_CW'(push_ok) - btd_pkg::Q_CW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_ent;
    end

endmodule

// ===== sv/btd_stage.sv =====
// ----------------------------------------------------------------------------
// btd_stage
// one dilation pass: pixel ring, diamond window and emission control
// ----------------------------------------------------------------------------
module btd_stage #(
    parameter int AW = 13
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  btd_pkg::t_geom i_geom,
    input  btd_pkg::t_tok  i_tok,
    output btd_pkg::t_tok  o_tok
);

    localparam int RING = 2 ** AW;
    localparam int TAPS = 5;

    logic [AW-1:0]              r_head;
    logic [AW-1:0]              r_pend;
    logic [btd_pkg::H_W-1:0]    r_orow;
    logic [btd_pkg::W_W-1:0]    r_ocol;
    logic [btd_pkg::FS_W-1:0]   r_idx;

    logic                       r_ring [TAPS][RING];
    logic [TAPS-1:0]            r_rd;
    logic [TAPS-1:0]            r_fw;
    logic                       r_fb;

    logic                       r_cv;
    logic                       r_ce;
    logic                       r_last;
    logic                       r_pass;
    logic [TAPS-1:0]            r_rok;
    logic [TAPS-1:0]            r_cok;

    logic [3:0]                 r_w0;   // row 0, columns -2 .. +1
    logic [1:0]                 r_wm1;  // row -1, columns -1 .. 0
    logic [1:0]                 r_wp1;  // row +1, columns -1 .. 0

    logic                       push;
    logic [AW-1:0]              w_a;
    logic [AW-1:0]              wa;
    logic [AW-1:0]              pend1;
    logic [AW-1:0]              head_p1;
    logic [AW-1:0]              addr [TAPS];
    logic [btd_pkg::W_W+1:0]    thr;
    logic                       emit;
    logic                       last;
    logic                       pass;
    logic                       col_wrap;
    logic                       row_wrap;
    logic [TAPS-1:0]            rok;
    logic [TAPS-1:0]            cok;
    logic [TAPS-1:0]            col;
    logic                       dil;

    assign push    = i_tok.valid && i_tok.have;
    assign w_a     = AW'(i_geom.w);
    assign wa      = r_head + r_pend;
    assign pend1   = r_pend + AW'(push);
    assign head_p1 = r_head + 1'b1;
    assign thr     = {1'b0, i_geom.w, 1'b0} + 13'd3;

    // ring positions of the column entering the window on this emission;
    // a pass-through pixel reads its own slot on the row -2 port, idle then
    assign addr[0] = pass ? r_head : r_head - (w_a << 1);
    assign addr[1] = r_head - w_a + 1'b1;
    assign addr[2] = r_head + 2'd2;
    assign addr[3] = r_head + w_a + 1'b1;
    assign addr[4] = r_head + (w_a << 1);

    assign emit = i_tok.valid && (pend1 != '0)
               && ((32'(pend1) >= 32'(thr))
                   || (32'(pend1) + 32'(r_idx) >= 32'(i_geom.fsize)));

    assign col_wrap = (32'(r_ocol) + 32'd1 >= 32'(i_geom.w));
    assign row_wrap = (32'(r_orow) + 32'd1 >= 32'(i_geom.h));
    assign last     = col_wrap && row_wrap;
    assign pass     = (r_orow == '0) || (r_ocol == '0);

    always_comb begin
        int rv;
        int cv;
        rok = '0;
        cok = '0;
        for (int k = 0; k < TAPS; k++) begin
            rv = int'(r_orow) + k - 2;
            cv = int'(r_ocol) + k - 2;
            rok[k] = (rv >= 2) && (rv <= int'(i_geom.h) - 3);
            cok[k] = (cv >= 2) && (cv <= int'(i_geom.w) - 3);
        end
    end

    // newest column, with a same-cycle write forwarded
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            col[k] = r_fw[k] ? r_fb : r_rd[k];
        end
    end

    // diamond of radius two, a source outside the valid band never darkens
    always_comb begin
        dil = 1'b1;
        for (int k = 0; k < 4; k++) begin
            dil &= r_w0[k] | !(r_rok[2] & r_cok[k]);
        end
        dil &= col[2]   | !(r_rok[2] & r_cok[4]);
        dil &= r_wm1[0] | !(r_rok[1] & r_cok[1]);
        dil &= r_wm1[1] | !(r_rok[1] & r_cok[2]);
        dil &= col[1]   | !(r_rok[1] & r_cok[3]);
        dil &= r_wp1[0] | !(r_rok[3] & r_cok[1]);
        dil &= r_wp1[1] | !(r_rok[3] & r_cok[2]);
        dil &= col[3]   | !(r_rok[3] & r_cok[3]);
        dil &= col[0]   | !(r_rok[0] & r_cok[2]);
        dil &= col[4]   | !(r_rok[4] & r_cok[2]);
    end

    assign o_tok.valid = r_cv;
    assign o_tok.have  = r_ce;
    assign o_tok.pix   = r_pass ? col[0] : dil;
    assign o_tok.last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_pend <= '0;
            r_orow <= '0;
            r_ocol <= '0;
            r_idx  <= '0;
            r_cv   <= 1'b0;
            r_ce   <= 1'b0;
            r_w0   <= '1;
            r_wm1  <= '1;
            r_wp1  <= '1;
        end else if (i_en) begin
            r_cv <= i_tok.valid;
            r_ce <= emit;
            if (i_tok.valid) begin
                r_pend <= emit ? pend1 - 1'b1 : pend1;
            end
            if (emit) begin
                r_head <= head_p1;
                r_idx  <= last ? '0 : r_idx + 1'b1;
                if (col_wrap) begin
                    r_ocol <= '0;
                    r_orow <= row_wrap ? '0 : r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
            if (r_cv && r_ce) begin
                r_w0  <= {col[2], r_w0[3:1]};
                r_wm1 <= {col[1], r_wm1[1]};
                r_wp1 <= {col[3], r_wp1[1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last <= last;
            r_pass <= pass;
            r_rok  <= rok;
            r_cok  <= cok;
            r_fb   <= i_tok.pix;
        end
    end

    // one copy of the ring per window row, each with its own read port
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TAPS; k++) begin
            if (i_en && push) r_ring[k][wa] <= i_tok.pix;
            if (i_en) begin
                r_rd[k] <= r_ring[k][addr[k]];
                r_fw[k] <= push && (wa == addr[k]);
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_head) && $stable(r_pend))
        else $error("stage state moved during a stall");

    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && emit) |=> (r_head == $past(head_p1)))
        else $error("ring head did not step on emission");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_tok.valid) |=> !r_ce)
        else $error("emission without an item");

endmodule

// ===== sv/btd_back.sv =====
// ----------------------------------------------------------------------------
// btd_back
// cascade of dilation passes and the result register
// ----------------------------------------------------------------------------
module btd_back #(
    parameter int PASSES = 4,
    parameter int AW     = 13
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  btd_pkg::t_geom  i_geom,
    input  btd_pkg::t_qent  i_ent,
    input  btd_pkg::t_qstat i_qstat,
    output logic            o_pop,
    btd_out_if.source       o_out
);

    btd_pkg::t_tok tok [PASSES+1];
    logic          en;
    logic          r_ov;
    logic          r_white;
    logic          r_last;

    // whole cascade steps together, frozen while a result waits
    assign en    = !r_ov || o_out.ready;
    assign o_pop = en;

    assign tok[0].valid = !i_qstat.empty;
    assign tok[0].have  = i_ent.have;
    assign tok[0].pix   = i_ent.pix;
    assign tok[0].last  = 1'b0;

    for (genvar s = 0; s < PASSES; s++) begin : g_pass
        btd_stage #(.AW(AW)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_geom  (i_geom),
            .i_tok   (tok[s]),
            .o_tok   (tok[s+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= tok[PASSES].valid && tok[PASSES].have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_white <= tok[PASSES].pix;
            r_last  <= tok[PASSES].last;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.is_white   = r_white;
    assign o_out.frame_last = r_last;

endmodule

// ===== sv/binary_threshold_dilate_top.sv =====
// ----------------------------------------------------------------------------
// binary_threshold_dilate_top
// rgb threshold to binary, then a cascade of diamond dilations of black
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           payload
//  i_in      in    valid / ready       kind, blue, green, red
//  o_out     out   valid / ready       is_white, frame_last
//  i_cfg_*   in    write enable only   index, data (width, height, limit)
//
//  one transaction per clock sustained while results are taken; a pixel leaves
//  about 2*W+2 pixels per pass later, plus front register, queue, the output
//  register of each pass and the result register
//  the rate is set by the single-cycle ring step of each pass: one write
//  and five reads on five ring copies per clock
//  synchronous active-low reset clears counters and valids; ring contents
//  are not cleared since an in-frame source is always written before use
//  a stalled result freezes the cascade; the queue keeps accepting input until full
//
module binary_threshold_dilate_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int PASSES    = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    btd_in_if.sink                       i_in,
    btd_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [btd_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [btd_pkg::LIM_W-1:0]    i_cfg_data
);

    // ring address width, ring must span at least 4*W+5 pixels
    localparam int AW = $clog2(5 * MAX_WIDTH);

    logic [btd_pkg::W_W-1:0]   r_width;
    logic [btd_pkg::H_W-1:0]   r_height;
    logic [btd_pkg::LIM_W-1:0] r_limit;
    btd_pkg::t_geom            r_geom;
    logic [btd_pkg::W_W-1:0]   n_w;
    logic [btd_pkg::H_W-1:0]   n_h;

    btd_pkg::t_qent            f_ent;
    btd_pkg::t_qent            q_ent;
    btd_pkg::t_qstat           q_stat;
    logic                      f_push;
    logic                      b_pop;

    // configuration writes, an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= btd_pkg::RST_WIDTH;
            r_height <= btd_pkg::RST_HEIGHT;
            r_limit  <= btd_pkg::RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (btd_pkg::t_cfg_idx'(i_cfg_idx))
                btd_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[btd_pkg::W_W-1:0];
                btd_pkg::CFG_HEIGHT: r_height <= i_cfg_data[btd_pkg::H_W-1:0];
                btd_pkg::CFG_DARK:   r_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp frame size to the supported range
    always_comb begin
        n_w = r_width;
        if (32'(r_width) < btd_pkg::MIN_SIDE) n_w = btd_pkg::W_W'(btd_pkg::MIN_SIDE);
        if (32'(r_width) > MAX_WIDTH)         n_w = btd_pkg::W_W'(MAX_WIDTH);
        n_h = r_height;
        if (32'(r_height) < btd_pkg::MIN_SIDE) n_h = btd_pkg::H_W'(btd_pkg::MIN_SIDE);
        if (32'(r_height) > btd_pkg::MAX_HEIGHT) n_h = btd_pkg::H_W'(btd_pkg::MAX_HEIGHT);
    end

    // clamped sides registered, pixels per frame registered from them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.w     <= btd_pkg::RST_WIDTH;
            r_geom.h     <= btd_pkg::RST_HEIGHT;
            r_geom.fsize <= btd_pkg::RST_FSIZE;
        end else begin
            r_geom.w     <= n_w;
            r_geom.h     <= n_h;
            r_geom.fsize <= btd_pkg::FS_W'(r_geom.w) * btd_pkg::FS_W'(r_geom.h);
        end
    end

    // front: accept and classify
    btd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_limit (r_limit),
        .i_qstat (q_stat),
        .o_push  (f_push),
        .o_ent   (f_ent)
    );

    // decoupling queue
    btd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_ent   (f_ent),
        .i_pop   (b_pop),
        .o_ent   (q_ent),
        .o_stat  (q_stat)
    );

    // back: dilation passes and result register
    btd_back #(
        .PASSES (PASSES),
        .AW     (AW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (r_geom),
        .i_ent   (q_ent),
        .i_qstat (q_stat),
        .o_pop   (b_pop),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/btd_tb_checker.sv =====
// ----------------------------------------------------------------------------
// btd_tb_checker
// watches the pixel, result and register ports, predicts the binary
// dilated stream and compares every result transaction in order
// ----------------------------------------------------------------------------
module btd_tb_checker #(
    parameter int MAX_WIDTH = 1024,
    parameter int PASSES    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    btd_in_if                          i_pix,
    btd_out_if                         i_res,
    input  logic                       i_cfg_we,
    input  btd_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [btd_pkg::LIM_W-1:0]  i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import btd_pkg::*;

    localparam int RING = 5 * MAX_WIDTH;

    typedef struct packed {
        logic is_white;
        logic frame_last;
    } t_bin_pix;

    bit              ring_bits [PASSES][RING];
    int              out_row   [PASSES];
    int              out_col   [PASSES];
    int              head      [PASSES];
    int              held      [PASSES];
    logic [W_W-1:0]   width_reg;
    logic [H_W-1:0]   height_reg;
    logic [LIM_W-1:0] dark_lim;
    t_bin_pix        expected_pix [$];

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < MIN_SIDE) w = MIN_SIDE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h < MIN_SIDE) h = MIN_SIDE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void step_pos(ref int row, ref int col, input int w, input int h);
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    // diamond of radius two around the oldest held pixel of stage s; row 0 or column 0 passes through
    function automatic bit grown_pixel(int s, int w, int h);
        int r, c, i, j, off;
        r = out_row[s];
        c = out_col[s];
        if (r == 0 || c == 0) return ring_bits[s][head[s] % RING];
        for (int di = -2; di <= 2; di++) begin
            for (int dj = -2; dj <= 2; dj++) begin
                i = r + di;
                j = c + dj;
                if ((di < 0 ? -di : di) + (dj < 0 ? -dj : dj) > 2) continue;
                if (i < 2 || i > h - 3 || j < 2 || j > w - 3) continue;
                off = di * w + dj;
                if (ring_bits[s][(head[s] + RING + off) % RING] == 1'b0) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_item(logic flush, logic [7:0] b, logic [7:0] g,
                                         logic [7:0] r);
        int       w, h, d;
        longint   remaining;
        bit       have, last, px;
        t_bin_pix res;
        w = eff_width();
        h = eff_height();
        d = 2 * w + 2;
        have = 0;
        last = 0;
        px = 0;
        if (!flush) begin
            px = (int'(b) * b + int'(g) * g + int'(r) * r < int'(dark_lim)) ? 1'b0 : 1'b1;
            have = 1;
        end
        for (int s = 0; s < PASSES; s++) begin
            if (have) begin
                ring_bits[s][(head[s] + held[s]) % RING] = px;
                held[s]++;
            end
            have = 0;
            if (held[s] == 0) continue;
            remaining = longint'(w) * h - (longint'(out_row[s]) * w + out_col[s]);
            if (remaining < 1) remaining = 1;
            if (held[s] >= d + 1 || held[s] >= remaining) begin
                px   = grown_pixel(s, w, h);
                last = (out_col[s] + 1 >= w) && (out_row[s] + 1 >= h);
                step_pos(out_row[s], out_col[s], w, h);
                head[s] = (head[s] + 1) % RING;
                held[s]--;
                have = 1;
            end
        end
        if (have) begin
            res.is_white   = px;
            res.frame_last = last;
            expected_pix.push_back(res);
        end
    endfunction

    assign o_pending = expected_pix.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_bin_pix want;
        if (!i_rst_n) begin
            foreach (ring_bits[s, k]) ring_bits[s][k] = 1'b1;
            for (int s = 0; s < PASSES; s++) begin
                out_row[s] = 0;
                out_col[s] = 0;
                head[s]    = 0;
                held[s]    = 0;
            end
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            dark_lim   = RST_LIMIT;
            expected_pix.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  width_reg  = i_cfg_data[W_W-1:0];
                    CFG_HEIGHT: height_reg = i_cfg_data[H_W-1:0];
                    CFG_DARK:   dark_lim   = i_cfg_data;
                    default: ;
                endcase
            end
            // input first; a result can never leave on the edge its pixel arrives
            if (i_pix.valid && i_pix.ready)
                predict_item(i_pix.kind, i_pix.blue, i_pix.green, i_pix.red);
            if (i_res.valid && i_res.ready) begin
                if (expected_pix.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result: is_white=%0b frame_last=%0b",
                                 i_res.is_white, i_res.frame_last);
                end else begin
                    want = expected_pix.pop_front();
                    if (want.is_white !== i_res.is_white
                            || want.frame_last !== i_res.frame_last) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: is_white exp %0b got %0b, frame_last exp %0b got %0b",
                                     want.is_white, i_res.is_white,
                                     want.frame_last, i_res.frame_last);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives whole frames of rgb pixels and flushes through the threshold and
// dilation block under several sizes and limits, with random idling on both
// channels; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    import btd_pkg::*;

    localparam int MAX_WIDTH = 1024;
    localparam int PASSES    = 4;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [LIM_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    bit               quiet;        // no idling in the closing part
    bit               hold_req;     // asks the receiver for one long hold-off
    int               random_pix;

    btd_in_if  pix_ch ();
    btd_out_if res_ch ();

    binary_threshold_dilate_top #(.MAX_WIDTH(MAX_WIDTH), .PASSES(PASSES)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (pix_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    btd_tb_checker #(.MAX_WIDTH(MAX_WIDTH), .PASSES(PASSES)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: short random stalls, one long hold-off on request
    initial begin
        res_ch.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // one register write, only while nothing is in flight
    task automatic write_reg(t_cfg_idx idx, logic [LIM_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // one transaction on the pixel channel; valid stays up between back-to-back items
    task automatic send_item(logic kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.kind  <= kind;
        pix_ch.blue  <= b;
        pix_ch.green <= g;
        pix_ch.red   <= r;
        do @(posedge clk); while (!pix_ch.ready);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(0, 70));
            default: return 8'($urandom);
        endcase
    endfunction

    // full frames followed by enough flushes to drain every pass
    task automatic run_frames(int wr, int hr, int lim, int nframes, bit stall_mid,
                              bit pause_mid);
        int w, h, npix;
        w = (wr < MIN_SIDE) ? MIN_SIDE : (wr > MAX_WIDTH ? MAX_WIDTH : wr);
        h = (hr < MIN_SIDE) ? MIN_SIDE : (hr > MAX_HEIGHT ? MAX_HEIGHT : hr);
        npix = w * h;
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        write_reg(CFG_WIDTH, LIM_W'(wr));
        write_reg(CFG_HEIGHT, LIM_W'(hr));
        write_reg(CFG_DARK, LIM_W'(lim));
        for (int f = 0; f < nframes; f++) begin
            for (int p = 0; p < npix; p++) begin
                if (stall_mid && f == 0 && p == npix / 2) hold_req = 1'b1;
                if (pause_mid && f == 0 && p == npix / 2) begin
                    pix_ch.valid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
                // stray flush inside a frame is only a bubble
                if ($urandom_range(0, 15) == 0)
                    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
                send_item(1'b0, pick_chan(), pick_chan(), pick_chan());
                random_pix++;
            end
        end
        repeat (PASSES * (2 * w + 4) + 8)
            send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        pix_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] edge_val [4];
        cfg_we       = 1'b0;
        cfg_idx      = CFG_WIDTH;
        cfg_data     = '0;
        pix_ch.valid = 1'b0;
        pix_ch.kind  = 1'b0;
        pix_ch.blue  = '0;
        pix_ch.green = '0;
        pix_ch.red   = '0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        random_pix   = 0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed 5x5 frame: channel extremes, a flush and a threshold edge
        edge_val = '{8'd0, 8'd255, 8'd127, 8'd128};
        write_reg(CFG_WIDTH, LIM_W'(5));
        write_reg(CFG_HEIGHT, LIM_W'(5));
        write_reg(CFG_DARK, LIM_W'(16384));
        for (int p = 0; p < 25; p++) begin
            if (p == 12) send_item(1'b1, 8'd255, 8'd255, 8'd255);
            send_item(1'b0, edge_val[p % 4], edge_val[(p / 4) % 4], edge_val[(p / 2) % 4]);
        end
        repeat (PASSES * 14 + 8) send_item(1'b1, 8'd0, 8'd0, 8'd0);
        pix_ch.valid <= 1'b0;

        // size clamping and limit extremes
        run_frames(0, 3, 0, 1, 1'b0, 1'b0);
        run_frames(7, 6, 195075, 1, 1'b1, 1'b0);
        run_frames(5, 5, 16384, 2, 1'b0, 1'b1);

        // random sizes and limits
        random_pix = 0;
        while (random_pix < 80) begin
            run_frames($urandom_range(5, 12), $urandom_range(5, 10),
                       ($urandom_range(0, 1) != 0) ? $urandom_range(0, 195075)
                                                   : $urandom_range(8000, 40000),
                       $urandom_range(1, 3), $urandom_range(0, 9) == 0,
                       $urandom_range(0, 9) == 0);
        end

        // closing part with no idling at all
        quiet = 1'b1;
        run_frames(9, 7, 16384, 1, 1'b0, 1'b0);

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
